### rtl/ksw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ksw_pkg: shared types and constants of the keyed square wave generator
// Opcodes, register indexes, controller states, field widths, register reset
// values and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package ksw_pkg;

   // field widths fixed by the interface
   localparam int RATE_WIDTH      = 24;
   localparam int TRIM_WIDTH      = 8;
   localparam int LIMIT_WIDTH     = 14;
   localparam int DIVIDE_WIDTH    = 8;
   localparam int DIGIT_WIDTH     = 4;
   localparam int OPCODE_WIDTH    = 2;
   localparam int VALUE_OUT_WIDTH = 14;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 24;

   // one quotient bit per divider step
   localparam int STEP_WIDTH = $clog2(RATE_WIDTH);

   // register reset values
   localparam logic [RATE_WIDTH-1:0]   TICK_RATE_RESET    = 24'd921659;
   localparam logic [TRIM_WIDTH-1:0]   LATENCY_TRIM_RESET = 8'd9;
   localparam logic [LIMIT_WIDTH-1:0]  SLOW_LIMIT_RESET   = 14'd7;
   localparam logic [DIVIDE_WIDTH-1:0] SLOW_DIVIDE_RESET  = 8'd20;

   localparam logic [DIGIT_WIDTH-1:0] DIGIT_MAX = 4'd9;

   typedef enum logic [OPCODE_WIDTH-1:0] {
      OP_TICK  = 2'd0,
      OP_DIGIT = 2'd1,
      OP_START = 2'd2,
      OP_SPARE = 2'd3
   } opcode_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_TICK_RATE    = 2'd0,
      CSR_LATENCY_TRIM = 2'd1,
      CSR_SLOW_LIMIT   = 2'd2,
      CSR_SLOW_DIVIDE  = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE   = 2'd0,
      ST_MULT   = 2'd1,
      ST_DIVIDE = 2'd2,
      ST_FINISH = 2'd3
   } ctl_state_type;

   // controller to datapath
   typedef struct packed {
      logic exec_item;     // tick, digit or spare opcode
      logic reply_zero;    // start with zero frequency: flag, keep state
      logic begin_calc;    // latch the divider choice
      logic load_divisor;  // form 2*f*D and load the dividend
      logic div_step;      // one restoring division step
      logic commit;        // trim, saturate and arm the counter
   } ksw_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic value_zero;
   } ksw_status_type;

endpackage
`default_nettype wire

### rtl/keyed_square_wave_generator.sv
// Tick, digit and spare requests: response in the cycle after acceptance, one per
// cycle while the receiver does not stall. Nonzero starts: response after a multiply
// step, the bit-serial divider at one quotient bit per step, a trim/saturate step and
// the output register; no request is accepted meanwhile. Zero starts are flagged.
// Synchronous reset clears digits, counter and armed flag, sets the level high and
// restores the register defaults; the block accepts requests once reset is released.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// keyed_square_wave_generator: top level
// Decimal frequency entry and a programmable square wave counter, built from
// a request sequencer and a datapath.
// ----------------------------------------------------------------------------
module keyed_square_wave_generator #(
   parameter int COUNT_WIDTH = 16,
   parameter int DIGIT_COUNT = 4
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [ksw_pkg::OPCODE_WIDTH-1:0]       req_opcode,
   input  logic [ksw_pkg::DIGIT_WIDTH-1:0]        req_digit_value,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic                                   rsp_wave_level,
   output logic [ksw_pkg::VALUE_OUT_WIDTH-1:0]    rsp_entered_value,
   output logic                                   rsp_zero_error,
   output logic                                   rsp_running,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [ksw_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [ksw_pkg::CSR_DATA_WIDTH-1:0]     csr_data
);
   import ksw_pkg::*;

   ksw_cmd_type    cmd;
   ksw_status_type status;
   logic           csr_write;

   // register writes land at once
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   ksw_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_opcode (req_opcode),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .status     (status),
      .cmd        (cmd)
   );

   ksw_datapath #(
      .COUNT_WIDTH (COUNT_WIDTH),
      .DIGIT_COUNT (DIGIT_COUNT)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_opcode        (req_opcode),
      .req_digit_value   (req_digit_value),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .rsp_wave_level    (rsp_wave_level),
      .rsp_entered_value (rsp_entered_value),
      .rsp_zero_error    (rsp_zero_error),
      .rsp_running       (rsp_running)
   );

endmodule
`default_nettype wire

### rtl/ksw_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ksw_ctrl: request sequencer
// Accepts requests, steps the datapath through the half period calculation
// and owns the response valid flag.
// ----------------------------------------------------------------------------
module ksw_ctrl (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [ksw_pkg::OPCODE_WIDTH-1:0]     req_opcode,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   input  ksw_pkg::ksw_status_type              status,
   output ksw_pkg::ksw_cmd_type                 cmd
);
   import ksw_pkg::*;

   localparam logic [STEP_WIDTH-1:0] LAST_STEP = STEP_WIDTH'(RATE_WIDTH - 1);

   ctl_state_type           state_ff, state_in;
   logic [STEP_WIDTH-1:0]   step_ff, step_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    req_accept;

   // state, step counter and response flag
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      step_in    = step_ff;
      cmd        = '0;
      req_stall  = 1'b1;
      req_accept = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_stall  = rsp_valid_ff && rsp_stall;
            req_accept = req_valid && !req_stall;
            if (req_accept) begin
               if (opcode_type'(req_opcode) == OP_START) begin
                  if (status.value_zero) begin
                     cmd.reply_zero = 1'b1;
                  end else begin
                     cmd.begin_calc = 1'b1;
                     state_in       = ST_MULT;
                  end
               end else begin
                  cmd.exec_item = 1'b1;
               end
            end
         end
         ST_MULT: begin
            cmd.load_divisor = 1'b1;
            step_in          = '0;
            state_in         = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff + 1'b1;
            if (step_ff == LAST_STEP) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            cmd.commit = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      // hold a response until taken, load a new one when produced
      rsp_valid_in = cmd.exec_item || cmd.reply_zero || cmd.commit ||
                     (rsp_valid_ff && rsp_stall);
   end

   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

### rtl/ksw_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ksw_datapath: digit entry, half period divider and wave counter
// Holds the configuration registers, the entered digits and their binary
// value, a bit-serial restoring divider, the tick counter and the response
// register.
// ----------------------------------------------------------------------------
module ksw_datapath #(
   parameter int COUNT_WIDTH = 16,
   parameter int DIGIT_COUNT = 4
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  ksw_pkg::ksw_cmd_type                   cmd,
   output ksw_pkg::ksw_status_type                status,
   input  logic [ksw_pkg::OPCODE_WIDTH-1:0]       req_opcode,
   input  logic [ksw_pkg::DIGIT_WIDTH-1:0]        req_digit_value,
   input  logic                                   csr_write,
   input  logic [ksw_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [ksw_pkg::CSR_DATA_WIDTH-1:0]     csr_data,
   output logic                                   rsp_wave_level,
   output logic [ksw_pkg::VALUE_OUT_WIDTH-1:0]    rsp_entered_value,
   output logic                                   rsp_zero_error,
   output logic                                   rsp_running
);
   import ksw_pkg::*;

   localparam int VALUE_WIDTH = $clog2(10 ** DIGIT_COUNT);
   localparam int PROD_WIDTH  = VALUE_WIDTH + DIVIDE_WIDTH;
   localparam int DIV_WIDTH   = PROD_WIDTH + 1;
   localparam int CMP_WIDTH   = DIV_WIDTH + RATE_WIDTH + 1;
   localparam int SAT_WIDTH   = RATE_WIDTH + COUNT_WIDTH;
   localparam int EXT_WIDTH   = VALUE_WIDTH + VALUE_OUT_WIDTH;

   // configuration
   logic [RATE_WIDTH-1:0]   tick_rate_ff;
   logic [TRIM_WIDTH-1:0]   latency_trim_ff;
   logic [LIMIT_WIDTH-1:0]  slow_limit_ff;
   logic [DIVIDE_WIDTH-1:0] slow_divide_ff;

   // architectural state
   logic [DIGIT_WIDTH-1:0]  digits_ff [DIGIT_COUNT];
   logic [DIGIT_WIDTH-1:0]  digits_in [DIGIT_COUNT];
   logic [VALUE_WIDTH-1:0]  value_ff, value_in;
   logic [COUNT_WIDTH-1:0]  half_period_ff, half_period_in;
   logic [COUNT_WIDTH-1:0]  tick_remaining_ff, tick_remaining_in;
   logic [DIVIDE_WIDTH-1:0] toggle_every_ff, toggle_every_in;
   logic [DIVIDE_WIDTH-1:0] reload_count_ff, reload_count_in;
   logic                    level_ff, level_in;
   logic                    armed_ff, armed_in;

   // divider
   logic [DIVIDE_WIDTH-1:0] divider_ff;
   logic [DIV_WIDTH-1:0]    divisor_ff;
   logic [RATE_WIDTH-1:0]   quot_ff;
   logic [RATE_WIDTH-1:0]   rem_ff;

   // response register
   logic                       rsp_wave_level_ff;
   logic [VALUE_OUT_WIDTH-1:0] rsp_entered_value_ff;
   logic                       rsp_zero_error_ff;
   logic                       rsp_running_ff;

   // combinational helpers
   opcode_type                 opcode;
   logic [DIGIT_WIDTH-1:0]     digit_sat;
   logic                       top_zero;
   logic [VALUE_WIDTH+3:0]     value_wide;
   logic [VALUE_WIDTH+3:0]     value_shifted;
   logic [DIVIDE_WIDTH-1:0]    reload_base;
   logic                       use_slow;
   logic [DIVIDE_WIDTH-1:0]    divider_sel;
   logic [PROD_WIDTH-1:0]      product;
   logic [RATE_WIDTH:0]        trial;
   logic [CMP_WIDTH-1:0]       trial_wide;
   logic [CMP_WIDTH-1:0]       divisor_wide;
   logic [CMP_WIDTH-1:0]       trial_diff;
   logic                       trial_fits;
   logic                       quot_small;
   logic [RATE_WIDTH-1:0]      quot_trimmed;
   logic [SAT_WIDTH-1:0]       quot_wide;
   logic [SAT_WIDTH-1:0]       count_max_wide;
   logic [COUNT_WIDTH-1:0]     period_calc;
   logic [EXT_WIDTH-1:0]       value_ext;

   assign opcode = opcode_type'(req_opcode);

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         tick_rate_ff    <= TICK_RATE_RESET;
         latency_trim_ff <= LATENCY_TRIM_RESET;
         slow_limit_ff   <= SLOW_LIMIT_RESET;
         slow_divide_ff  <= SLOW_DIVIDE_RESET;
      end else if (csr_write) begin
         case (csr_index_type'(csr_index))
            CSR_TICK_RATE:    tick_rate_ff    <= csr_data[RATE_WIDTH-1:0];
            CSR_LATENCY_TRIM: latency_trim_ff <= csr_data[TRIM_WIDTH-1:0];
            CSR_SLOW_LIMIT:   slow_limit_ff   <= csr_data[LIMIT_WIDTH-1:0];
            CSR_SLOW_DIVIDE:  slow_divide_ff  <= csr_data[DIVIDE_WIDTH-1:0];
            default: begin
            end
         endcase
      end
   end

   // digit entry: shift up while the top digit is clear, else restart
   assign digit_sat     = (req_digit_value > DIGIT_MAX) ? DIGIT_MAX : req_digit_value;
   assign top_zero      = (digits_ff[DIGIT_COUNT-1] == '0);
   assign value_wide    = (VALUE_WIDTH + 4)'(value_ff);
   assign value_shifted = (value_wide << 3) + (value_wide << 1) +
                          (VALUE_WIDTH + 4)'(digit_sat);

   // half period: trim, then saturate to the counter range
   assign quot_small     = (quot_ff <= RATE_WIDTH'(latency_trim_ff));
   assign quot_trimmed   = quot_ff - RATE_WIDTH'(latency_trim_ff);
   assign quot_wide      = SAT_WIDTH'(quot_trimmed);
   assign count_max_wide = SAT_WIDTH'({COUNT_WIDTH{1'b1}});
   always_comb begin
      if (quot_small) begin
         period_calc = COUNT_WIDTH'(1);
      end else if (quot_wide > count_max_wide) begin
         period_calc = {COUNT_WIDTH{1'b1}};
      end else begin
         period_calc = quot_wide[COUNT_WIDTH-1:0];
      end
   end

   assign reload_base = (reload_count_ff == '0) ? toggle_every_ff : reload_count_ff;

   // next architectural state
   always_comb begin
      for (int k = 0; k < DIGIT_COUNT; k++) begin
         digits_in[k] = digits_ff[k];
      end
      value_in          = value_ff;
      half_period_in    = half_period_ff;
      tick_remaining_in = tick_remaining_ff;
      toggle_every_in   = toggle_every_ff;
      reload_count_in   = reload_count_ff;
      level_in          = level_ff;
      armed_in          = armed_ff;
      if (cmd.exec_item && opcode == OP_DIGIT) begin
         for (int k = DIGIT_COUNT - 1; k > 0; k--) begin
            digits_in[k] = top_zero ? digits_ff[k-1] : '0;
         end
         digits_in[0] = digit_sat;
         value_in     = top_zero ? value_shifted[VALUE_WIDTH-1:0]
                                 : VALUE_WIDTH'(digit_sat);
      end
      if (cmd.exec_item && opcode == OP_TICK && armed_ff) begin
         if (tick_remaining_ff[COUNT_WIDTH-1:1] != '0) begin
            tick_remaining_in = tick_remaining_ff - 1'b1;
         end else begin
            tick_remaining_in = half_period_ff;
            if (reload_base == toggle_every_ff) begin
               level_in = ~level_ff;
            end
            reload_count_in = reload_base - 1'b1;
         end
      end
      if (cmd.commit) begin
         half_period_in    = period_calc;
         tick_remaining_in = period_calc;
         toggle_every_in   = divider_ff;
         reload_count_in   = divider_ff;
         armed_in          = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DIGIT_COUNT; k++) begin
            digits_ff[k] <= '0;
         end
         value_ff          <= '0;
         half_period_ff    <= '0;
         tick_remaining_ff <= '0;
         toggle_every_ff   <= '0;
         reload_count_ff   <= '0;
         level_ff          <= 1'b1;
         armed_ff          <= 1'b0;
      end else begin
         for (int k = 0; k < DIGIT_COUNT; k++) begin
            digits_ff[k] <= digits_in[k];
         end
         value_ff          <= value_in;
         half_period_ff    <= half_period_in;
         tick_remaining_ff <= tick_remaining_in;
         toggle_every_ff   <= toggle_every_in;
         reload_count_ff   <= reload_count_in;
         level_ff          <= level_in;
         armed_ff          <= armed_in;
      end
   end

   // divider choice: slow divide at or below the limit, zero counts as one
   assign use_slow    = (EXT_WIDTH'(value_ff) <= EXT_WIDTH'(slow_limit_ff));
   assign divider_sel = (use_slow && slow_divide_ff != '0) ? slow_divide_ff
                                                           : DIVIDE_WIDTH'(1);
   assign product     = PROD_WIDTH'(value_ff) * PROD_WIDTH'(divider_ff);

   // restoring division step: one quotient bit a cycle
   assign trial        = {rem_ff, quot_ff[RATE_WIDTH-1]};
   assign trial_wide   = CMP_WIDTH'(trial);
   assign divisor_wide = CMP_WIDTH'(divisor_ff);
   assign trial_fits   = (trial_wide >= divisor_wide);
   assign trial_diff   = trial_wide - divisor_wide;

   always_ff @(posedge clock) begin
      if (cmd.begin_calc) begin
         divider_ff <= divider_sel;
      end
      if (cmd.load_divisor) begin
         divisor_ff <= {product, 1'b0};
         quot_ff    <= tick_rate_ff;
         rem_ff     <= '0;
      end else if (cmd.div_step) begin
         rem_ff  <= trial_fits ? trial_diff[RATE_WIDTH-1:0] : trial[RATE_WIDTH-1:0];
         quot_ff <= {quot_ff[RATE_WIDTH-2:0], trial_fits};
      end
   end

   // response register
   assign value_ext = EXT_WIDTH'(value_in);
   always_ff @(posedge clock) begin
      if (cmd.exec_item || cmd.reply_zero || cmd.commit) begin
         rsp_wave_level_ff    <= level_in;
         rsp_entered_value_ff <= value_ext[VALUE_OUT_WIDTH-1:0];
         rsp_zero_error_ff    <= cmd.reply_zero;
         rsp_running_ff       <= armed_in;
      end
   end

   assign status.value_zero = (value_ff == '0);
   assign rsp_wave_level    = rsp_wave_level_ff;
   assign rsp_entered_value = rsp_entered_value_ff;
   assign rsp_zero_error    = rsp_zero_error_ff;
   assign rsp_running       = rsp_running_ff;

endmodule
`default_nettype wire

### rtl/ksw_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ksw_checker: port level checks
// Response holding, response timing and the sticky running flag.
// ----------------------------------------------------------------------------
module ksw_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_stall,
   input logic [ksw_pkg::OPCODE_WIDTH-1:0]     req_opcode,
   input logic                                 rsp_valid,
   input logic                                 rsp_stall,
   input logic                                 rsp_wave_level,
   input logic [ksw_pkg::VALUE_OUT_WIDTH-1:0]  rsp_entered_value,
   input logic                                 rsp_zero_error,
   input logic                                 rsp_running
);
   import ksw_pkg::*;

   // hold a stalled response
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_wave_level) &&
         $stable(rsp_entered_value) && $stable(rsp_zero_error) && $stable(rsp_running))
      else $error("stalled response changed");

   // tick, digit and spare requests answer in the next cycle without error
   a_quick_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_opcode != OP_START |=> rsp_valid && !rsp_zero_error)
      else $error("single cycle request gave no clean response");

   // a start either answers at once or blocks further requests
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_opcode == OP_START |=> rsp_valid || req_stall)
      else $error("request taken while a start was in progress");

   // once armed, stay armed
   a_running_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_running |=> !rsp_valid || rsp_running)
      else $error("running flag dropped");

endmodule

bind keyed_square_wave_generator ksw_checker u_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_stall         (req_stall),
   .req_opcode        (req_opcode),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_wave_level    (rsp_wave_level),
   .rsp_entered_value (rsp_entered_value),
   .rsp_zero_error    (rsp_zero_error),
   .rsp_running       (rsp_running)
);
`default_nettype wire

### tb/keyed_square_wave_generator_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_square_wave_generator_checker: response scoreboard
// Watches the request, response and register channels. Keeps its own copy of
// the digit store, the wave counter and the registers, predicts one response
// per accepted request and compares each accepted response, field by field,
// with the oldest prediction.
// ----------------------------------------------------------------------------
module keyed_square_wave_generator_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_stall,
   input  logic [ksw_pkg::OPCODE_WIDTH-1:0]     req_opcode,
   input  logic [ksw_pkg::DIGIT_WIDTH-1:0]      req_digit_value,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   input  logic                                 rsp_wave_level,
   input  logic [ksw_pkg::VALUE_OUT_WIDTH-1:0]  rsp_entered_value,
   input  logic                                 rsp_zero_error,
   input  logic                                 rsp_running,
   input  logic                                 csr_valid,
   input  logic                                 csr_ready,
   input  logic [ksw_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [ksw_pkg::CSR_DATA_WIDTH-1:0]   csr_data,
   output int                                   failure_count,
   output int                                   outstanding
);
   import ksw_pkg::*;

   localparam int COUNT_WIDTH = 16;
   localparam int DIGIT_COUNT = 4;
   localparam longint unsigned COUNT_MAX = (64'd1 << COUNT_WIDTH) - 64'd1;

   typedef struct packed {
      logic                       wave_level;
      logic [VALUE_OUT_WIDTH-1:0] entered_value;
      logic                       zero_error;
      logic                       running;
   } wave_result_type;

   // register copies
   logic [RATE_WIDTH-1:0]   tick_rate;
   logic [TRIM_WIDTH-1:0]   latency_trim;
   logic [LIMIT_WIDTH-1:0]  slow_limit;
   logic [DIVIDE_WIDTH-1:0] slow_divide;

   // generator state
   logic [DIGIT_WIDTH-1:0]  digit_store [DIGIT_COUNT];
   logic [COUNT_WIDTH-1:0]  half_period;
   logic [COUNT_WIDTH-1:0]  ticks_left;
   logic [7:0]              toggle_every;
   logic [7:0]              reloads_left;
   logic                    level;
   logic                    armed;

   wave_result_type expected_wave_q [$];
   wave_result_type oldest_wave;

   function automatic void restore_defaults();
      int k;
      tick_rate    = TICK_RATE_RESET;
      latency_trim = LATENCY_TRIM_RESET;
      slow_limit   = SLOW_LIMIT_RESET;
      slow_divide  = SLOW_DIVIDE_RESET;
      for (k = 0; k < DIGIT_COUNT; k++)
         digit_store[k] = '0;
      half_period  = '0;
      ticks_left   = '0;
      toggle_every = '0;
      reloads_left = '0;
      level        = 1'b1;
      armed        = 1'b0;
   endfunction

   // decimal value of the stored digits, most significant digit on top
   function automatic int unsigned stored_frequency();
      int unsigned value;
      int k;
      value = 0;
      for (k = DIGIT_COUNT - 1; k >= 0; k--)
         value = value * 10 + digit_store[k];
      return value;
   endfunction

   // shift a digit in, or restart entry once the top digit is occupied
   function automatic void shift_digit(input logic [DIGIT_WIDTH-1:0] digit);
      logic [DIGIT_WIDTH-1:0] clipped;
      int k;
      clipped = (digit > DIGIT_MAX) ? DIGIT_MAX : digit;
      if (digit_store[DIGIT_COUNT-1] == '0) begin
         for (k = DIGIT_COUNT - 1; k > 0; k--)
            digit_store[k] = digit_store[k-1];
      end else begin
         for (k = DIGIT_COUNT - 1; k > 0; k--)
            digit_store[k] = '0;
      end
      digit_store[0] = clipped;
   endfunction

   // work out the half period and arm the counter; zero frequency is refused
   function automatic logic arm_generator();
      longint unsigned freq;
      longint unsigned divide;
      longint unsigned rate;
      longint unsigned quotient;
      freq = stored_frequency();
      if (freq == 0)
         return 1'b0;
      divide = 1;
      if (freq <= slow_limit)
         divide = (slow_divide == '0) ? 64'd1 : 64'(slow_divide);
      rate = 64'(tick_rate);
      quotient = rate / (64'd2 * freq * divide);
      if (quotient <= 64'(latency_trim))
         quotient = 1;
      else
         quotient = quotient - 64'(latency_trim);
      if (quotient > COUNT_MAX)
         quotient = COUNT_MAX;
      half_period  = quotient[COUNT_WIDTH-1:0];
      ticks_left   = half_period;
      toggle_every = divide[7:0];
      reloads_left = divide[7:0];
      armed        = 1'b1;
      return 1'b1;
   endfunction

   // count a tick down; on reload toggle the level on the first of every D reloads
   function automatic void advance_tick();
      if (!armed)
         return;
      if (ticks_left > 1) begin
         ticks_left = ticks_left - 1'b1;
         return;
      end
      ticks_left = half_period;
      if (reloads_left == '0)
         reloads_left = toggle_every;
      if (reloads_left == toggle_every)
         level = ~level;
      reloads_left = reloads_left - 1'b1;
   endfunction

   function automatic wave_result_type predict_wave_result(input opcode_type op,
                                                           input logic [DIGIT_WIDTH-1:0] digit);
      wave_result_type result;
      logic zero_hit;
      zero_hit = 1'b0;
      case (op)
         OP_TICK:  advance_tick();
         OP_DIGIT: shift_digit(digit);
         OP_START: zero_hit = !arm_generator();
         default: ;
      endcase
      result.wave_level    = level;
      result.entered_value = VALUE_OUT_WIDTH'(stored_frequency());
      result.zero_error    = zero_hit;
      result.running       = armed;
      return result;
   endfunction

   task automatic check_field(input string field, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         failure_count++;
      end
   endtask

   // retire responses first: a response never belongs to a request of the same edge
   always @(posedge clock) begin
      if (reset) begin
         restore_defaults();
         expected_wave_q.delete();
         failure_count = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               CSR_TICK_RATE:    tick_rate    = csr_data[RATE_WIDTH-1:0];
               CSR_LATENCY_TRIM: latency_trim = csr_data[TRIM_WIDTH-1:0];
               CSR_SLOW_LIMIT:   slow_limit   = csr_data[LIMIT_WIDTH-1:0];
               CSR_SLOW_DIVIDE:  slow_divide  = csr_data[DIVIDE_WIDTH-1:0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_wave_q.size() == 0) begin
               $error("response with no request outstanding");
               failure_count++;
            end else begin
               oldest_wave = expected_wave_q.pop_front();
               check_field("wave_level", oldest_wave.wave_level, rsp_wave_level);
               check_field("entered_value", oldest_wave.entered_value, rsp_entered_value);
               check_field("zero_error", oldest_wave.zero_error, rsp_zero_error);
               check_field("running", oldest_wave.running, rsp_running);
            end
         end
         if (req_valid && !req_stall)
            expected_wave_q.push_back(predict_wave_result(opcode_type'(req_opcode),
                                                          req_digit_value));
      end
      outstanding = expected_wave_q.size();
   end

endmodule

### tb/keyed_square_wave_generator_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_square_wave_generator_test: testbench top
// Drives digit entry, start and tick requests in bursts against a receiver that
// stalls at random, reprograms the registers between phases and leaves the
// checking to the scoreboard beside the block.
// ----------------------------------------------------------------------------
module keyed_square_wave_generator_test;
   import ksw_pkg::*;

   localparam int ITEM_TOTAL     = 1950;
   localparam int PHASE_COUNT    = 6;
   localparam int HOLD_CYCLES    = 300;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES  = 40;
   localparam int DIGIT_COUNT_TB = 4;

   logic                       clock = 1'b0;
   logic                       reset;
   logic                       req_valid;
   logic                       req_stall;
   logic [OPCODE_WIDTH-1:0]    req_opcode;
   logic [DIGIT_WIDTH-1:0]     req_digit_value;
   logic                       rsp_valid;
   logic                       rsp_stall;
   logic                       rsp_wave_level;
   logic [VALUE_OUT_WIDTH-1:0] rsp_entered_value;
   logic                       rsp_zero_error;
   logic                       rsp_running;
   logic                       csr_valid;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0]  csr_data;

   int   failure_count;
   int   outstanding;
   int   requests_sent;
   int   burst_left;
   int   gap_max;
   int   stall_pct;
   int   idle_cycles;
   logic hold_request;
   logic hold_taken;

   int   stall_by_phase [PHASE_COUNT] = '{20, 0, 50, 30, 10, 70};
   int   gap_by_phase   [PHASE_COUNT] = '{3, 0, 8, 4, 0, 12};

   keyed_square_wave_generator u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_opcode        (req_opcode),
      .req_digit_value   (req_digit_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_wave_level    (rsp_wave_level),
      .rsp_entered_value (rsp_entered_value),
      .rsp_zero_error    (rsp_zero_error),
      .rsp_running       (rsp_running),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   keyed_square_wave_generator_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_opcode        (req_opcode),
      .req_digit_value   (req_digit_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_wave_level    (rsp_wave_level),
      .rsp_entered_value (rsp_entered_value),
      .rsp_zero_error    (rsp_zero_error),
      .rsp_running       (rsp_running),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .failure_count     (failure_count),
      .outstanding       (outstanding)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // receiver: random stalls, with one long hold-off counted here on request
   initial begin
      rsp_stall  = 1'b0;
      hold_taken = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request && !hold_taken) begin
            hold_taken = 1'b1;
            rsp_stall  = 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         rsp_stall = ($urandom_range(0, 99) < stall_pct);
      end
   end

   // drop the run once nothing has moved on any channel for too long
   initial begin
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("TEST FAILED");
      $finish;
   end

   // offer one request in the current burst and hold it until accepted
   task automatic send_request(input opcode_type op, input logic [DIGIT_WIDTH-1:0] digit);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, gap_max);
         if (gap > 0) begin
            req_valid = 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 48);
      end
      burst_left--;
      req_valid       = 1'b1;
      req_opcode      = op;
      req_digit_value = digit;
      do
         @(posedge clock);
      while (req_stall);
      @(negedge clock);
      requests_sent++;
   endtask

   task automatic send_ticks(input int count);
      repeat (count) send_request(OP_TICK, DIGIT_WIDTH'($urandom_range(0, 15)));
   endtask

   task automatic enter_digits(input int count);
      repeat (count) send_request(OP_DIGIT, DIGIT_WIDTH'($urandom_range(0, 9)));
   endtask

   // four zeros leave the store empty whatever it held
   task automatic clear_entry();
      repeat (DIGIT_COUNT_TB) send_request(OP_DIGIT, '0);
   endtask

   task automatic drain_results();
      while (outstanding != 0)
         @(negedge clock);
   endtask

   // upper data bits beyond the register width are ignored by the block
   task automatic write_register(input csr_index_type idx, input int unsigned value,
                                 input int width);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = CSR_DATA_WIDTH'(($urandom() << width) | value);
      do
         @(posedge clock);
      while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic configure_phase(input int phase);
      case (phase)
         1: begin
            // widest rate, no trim: low frequencies saturate the counter
            write_register(CSR_TICK_RATE, 24'hFFFFFF, RATE_WIDTH);
            write_register(CSR_LATENCY_TRIM, 0, TRIM_WIDTH);
            write_register(CSR_SLOW_LIMIT, 0, LIMIT_WIDTH);
            write_register(CSR_SLOW_DIVIDE, 255, DIVIDE_WIDTH);
         end
         2: begin
            // zero rate, full trim, zero divider: half period of one
            write_register(CSR_TICK_RATE, 0, RATE_WIDTH);
            write_register(CSR_LATENCY_TRIM, 255, TRIM_WIDTH);
            write_register(CSR_SLOW_LIMIT, 9999, LIMIT_WIDTH);
            write_register(CSR_SLOW_DIVIDE, 0, DIVIDE_WIDTH);
         end
         3: begin
            write_register(CSR_TICK_RATE, $urandom_range(1, 3000), RATE_WIDTH);
            write_register(CSR_LATENCY_TRIM, $urandom_range(0, 3), TRIM_WIDTH);
            write_register(CSR_SLOW_LIMIT, $urandom_range(0, 9999), LIMIT_WIDTH);
            write_register(CSR_SLOW_DIVIDE, $urandom_range(1, 4), DIVIDE_WIDTH);
         end
         4: begin
            write_register(CSR_TICK_RATE, $urandom_range(1, 60000), RATE_WIDTH);
            write_register(CSR_LATENCY_TRIM, $urandom_range(0, 31), TRIM_WIDTH);
            write_register(CSR_SLOW_LIMIT, $urandom_range(0, 16383), LIMIT_WIDTH);
            write_register(CSR_SLOW_DIVIDE, $urandom_range(0, 8), DIVIDE_WIDTH);
         end
         5: begin
            write_register(CSR_TICK_RATE, $urandom_range(1, 20000), RATE_WIDTH);
            write_register(CSR_LATENCY_TRIM, $urandom_range(0, 7), TRIM_WIDTH);
            write_register(CSR_SLOW_LIMIT, 9999, LIMIT_WIDTH);
            write_register(CSR_SLOW_DIVIDE, 255, DIVIDE_WIDTH);
         end
         default: ;
      endcase
   endtask

   // mostly entry, start and a run of ticks; the rest zero starts and noise
   task automatic random_sequence();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
         if ($urandom_range(0, 3) == 0)
            clear_entry();
         enter_digits($urandom_range(1, 4));
         send_request(OP_START, DIGIT_WIDTH'($urandom_range(0, 15)));
         send_ticks($urandom_range(4, 64));
      end else if (pick < 78) begin
         clear_entry();
         send_request(OP_START, DIGIT_WIDTH'($urandom_range(0, 15)));
         send_ticks($urandom_range(1, 8));
      end else if (pick < 92) begin
         repeat ($urandom_range(1, 6))
            send_request(opcode_type'($urandom_range(0, 3)), DIGIT_WIDTH'($urandom_range(0, 15)));
      end else begin
         repeat ($urandom_range(1, 6))
            send_request(OP_DIGIT, DIGIT_WIDTH'($urandom_range(0, 15)));
         send_ticks($urandom_range(1, 10));
      end
   endtask

   initial begin
      int phase;
      int phase_target;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_opcode      = OP_TICK;
      req_digit_value = '0;
      csr_valid       = 1'b0;
      csr_index       = CSR_TICK_RATE;
      csr_data        = '0;
      hold_request    = 1'b0;
      burst_left      = 0;
      requests_sent   = 0;
      gap_max         = 2;
      stall_pct       = 20;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: zero start from reset, idle tick, spare opcode, digit clipping
      send_request(OP_START, '0);
      send_request(OP_TICK, '0);
      send_request(OP_SPARE, 4'hF);
      send_request(OP_DIGIT, 4'hF);
      repeat (3) send_request(OP_DIGIT, 4'd9);
      // fifth digit restarts entry; five is on the slow divider
      send_request(OP_DIGIT, 4'd5);
      send_request(OP_START, '0);
      send_ticks(3);
      // re-arm while running at a fast frequency
      repeat (3) send_request(OP_DIGIT, 4'd9);
      send_request(OP_START, '0);
      send_ticks(3);
      // zero start while running keeps the generation going
      send_request(OP_DIGIT, '0);
      send_request(OP_START, '0);
      send_ticks(2);

      for (phase = 0; phase < PHASE_COUNT; phase++) begin
         // hold the sender until every response is back, then reprogram
         req_valid = 1'b0;
         drain_results();
         configure_phase(phase);
         gap_max   = gap_by_phase[phase];
         stall_pct = stall_by_phase[phase];
         if (phase == 3) begin
            hold_request = 1'b1;
            send_ticks(40);
         end
         phase_target = ITEM_TOTAL * (phase + 1) / PHASE_COUNT;
         while (requests_sent < phase_target)
            random_sequence();
      end

      req_valid = 1'b0;
      drain_results();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (failure_count == 0 && outstanding == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
